### rtl/core/humidity_sensor_frame_checker_macros.svh
// Assertion macros for the humidity sensor frame checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HUMIDITY_SENSOR_FRAME_CHECKER_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HSFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types, constants and the CRC-8 and divide-by-65535 helpers used by
// the humidity sensor frame checker.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUS_FAIL = 2'd1,
    STATUS_CRC_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } hsfc_entry_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  CRC_POLY = 8'h31;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] HUM_SPAN    = 15'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [14:0] TEMP_RESET  = 15'd2550;
  localparam logic [13:0] HUM_RESET   = 14'd6000;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [14:0] TEMP_MAX    = 15'd13000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // CRC-8, MSB first, over the high byte and then the low byte.
  // The shifts are linear, so synthesis reduces this to an XOR network.
  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0]  crc;
    logic [15:0] data;
    crc  = CRC_INIT;
    data = {hi, lo};
    for (int i = 15; i >= 0; i--) begin
      if (crc[7] ^ data[i]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // floor(p / 65535) for p up to 17500 * 65535. Since 65536 = 65535 + 1,
  // p >> 16 is off by at most one and the remainder estimate says when.
  function automatic logic [14:0] div_full_scale(input logic [30:0] p);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = p[30:16];
    r0 = {1'b0, p[15:0]} + {2'b00, q0};
    if (r0 >= FULL_SCALE) begin
      return q0 + 15'd1;
    end
    return q0;
  endfunction

endpackage

### rtl/core/hsfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_front
// Accepts a sensor frame, checks both CRC bytes and classifies the frame
// before pushing it into the queue toward the conversion stage.
// ----------------------------------------------------------------------------
module hsfc_front import hsfc_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        transfer_ok,
  input  logic [7:0]  temp_msb,
  input  logic [7:0]  temp_lsb,
  input  logic [7:0]  temp_crc,
  input  logic [7:0]  hum_msb,
  input  logic [7:0]  hum_lsb,
  input  logic [7:0]  hum_crc,
  input  logic        queue_full,
  output logic        push,
  output hsfc_entry_t push_entry
);

  logic crc_good;

  assign crc_good = (crc8_word(temp_msb, temp_lsb) == temp_crc) &&
                    (crc8_word(hum_msb, hum_lsb) == hum_crc);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_entry.raw_t = {temp_msb, temp_lsb};
    push_entry.raw_h = {hum_msb, hum_lsb};
    // A bus failure wins over any CRC result.
    priority if (!transfer_ok) begin
      push_entry.status = STATUS_BUS_FAIL;
    end else if (!crc_good) begin
      push_entry.status = STATUS_CRC_FAIL;
    end else begin
      push_entry.status = STATUS_OK;
    end
  end

endmodule

### rtl/core/hsfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_queue
// Small FIFO of classified frames between the front and the conversion stage.
// ----------------------------------------------------------------------------
module hsfc_queue import hsfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hsfc_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        pop_valid,
  output hsfc_entry_t pop_entry
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  hsfc_entry_t         slots [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_pop;

  assign full      = (count == CntW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/hsfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_back
// Scales the raw words to hundredths, keeps the held readings and drives the
// registered result word.
// ----------------------------------------------------------------------------
module hsfc_back import hsfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  hsfc_entry_t        q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [1:0]         status,
  output logic               ready_res,
  output logic signed [14:0] held_temperature,
  output logic [13:0]        held_humidity
);

  // Multiply stage.
  logic        a_valid;
  status_t     a_status;
  logic [30:0] a_prod_t;
  logic [30:0] a_prod_h;

  logic        out_ready;
  logic        a_ready;
  logic        a_move;

  logic [14:0]        q_t;
  logic [14:0]        q_h;
  logic signed [15:0] temp_wide;
  logic signed [14:0] held_temperature_next;
  logic [13:0]        held_humidity_next;

  assign out_ready = !out_valid || !out_stall;
  assign a_ready   = !a_valid || out_ready;
  assign q_pop     = a_ready;
  assign a_move    = a_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && q_valid) begin
      a_status <= q_entry.status;
      a_prod_t <= 31'(q_entry.raw_t) * 31'(TEMP_SPAN);
      a_prod_h <= 31'(q_entry.raw_h) * 31'(HUM_SPAN);
    end
  end

  assign q_t       = div_full_scale(a_prod_t);
  assign q_h       = div_full_scale(a_prod_h);
  assign temp_wide = $signed({1'b0, q_t}) - $signed(TEMP_OFFSET);

  always_comb begin
    if (a_status == STATUS_OK) begin
      held_temperature_next = temp_wide[14:0];
      held_humidity_next    = q_h[13:0];
    end else begin
      held_temperature_next = held_temperature;
      held_humidity_next    = held_humidity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      held_temperature <= TEMP_RESET;
      held_humidity    <= HUM_RESET;
    end else begin
      if (out_ready) begin
        out_valid <= a_valid;
      end
      if (a_move) begin
        held_temperature <= held_temperature_next;
        held_humidity    <= held_humidity_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      temperature_centi <= held_temperature_next;
      humidity_centi    <= held_humidity_next;
      status            <= a_status;
      ready_res         <= (a_status == STATUS_OK);
    end
  end

endmodule

### rtl/core/humidity_sensor_frame_checker.sv
`timescale 1ns / 1ps
// A result word is registered in the queue, in the multiply stage and in the output register.
// Throughput: one frame per cycle while out_stall is low; the CRC check,
// the constant multiply and the divide-by-65535 correction each take one stage.
// A two-entry queue decouples input and output, so the input stalls only when it fills.
// Reset is synchronous and sets the held readings to 25.50 C and 60.00 percent.
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker
// Checks six-byte temperature/humidity sensor frames and converts the
// readings to hundredths, holding the last good values across failures.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_checker import hsfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               transfer_ok,
  input  logic [7:0]         temp_msb,
  input  logic [7:0]         temp_lsb,
  input  logic [7:0]         temp_crc,
  input  logic [7:0]         hum_msb,
  input  logic [7:0]         hum_lsb,
  input  logic [7:0]         hum_crc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [1:0]         status,
  output logic               ready_res
);

`include "humidity_sensor_frame_checker_macros.svh"

  logic               queue_full;
  logic               push;
  hsfc_entry_t        push_entry;
  logic               pop;
  logic               pop_valid;
  hsfc_entry_t        pop_entry;
  logic signed [14:0] held_temperature;
  logic [13:0]        held_humidity;
  logic               shown_is_held;
  logic               ready_agrees;
  logic               good_in_range;

  hsfc_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .transfer_ok (transfer_ok),
    .temp_msb    (temp_msb),
    .temp_lsb    (temp_lsb),
    .temp_crc    (temp_crc),
    .hum_msb     (hum_msb),
    .hum_lsb     (hum_lsb),
    .hum_crc     (hum_crc),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  hsfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  hsfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (pop_valid),
    .q_entry           (pop_entry),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .status            (status),
    .ready_res         (ready_res),
    .held_temperature  (held_temperature),
    .held_humidity     (held_humidity)
  );

  assign shown_is_held = (temperature_centi == held_temperature) &&
                         (humidity_centi == held_humidity);
  assign ready_agrees  = (ready_res == (status == STATUS_OK));
  assign good_in_range = (humidity_centi <= HUM_MAX) &&
                         (temperature_centi <= $signed(TEMP_MAX));

  // While out_valid is high, the shown word matches the readings held after it.
  `HSFC_ASSERT_NOW(a_out_matches_held, out_valid, shown_is_held, "word differs from held readings")
  `HSFC_ASSERT_NOW(a_ready_tracks_status, out_valid, ready_agrees, "ready flag and status disagree")
  `HSFC_ASSERT_NOW(a_good_in_range, out_valid && ready_res, good_in_range, "reading out of range")

endmodule
